/* src/union_find_edge_filter_assert.svh */
// Assertion macros shared by the union-find edge filter.
`ifndef UNION_FIND_EDGE_FILTER_ASSERT_SVH
`define UNION_FIND_EDGE_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UFEF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define UFEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ufef_pkg.sv */
// Shared constants and controller/datapath interface types of the union-find edge filter.
package ufef_pkg;

	localparam int NODES  = 1024;
	localparam int NODE_W = 10;
	localparam int LEN_W  = 32;
	localparam int CNT_W  = 10;

	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(1023);
	localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;       // capture an accepted input transfer
		logic clear_count;   // zero the new road counter
		logic sweep_wr;      // write one entry of the clearing pass
		logic rd_node;       // read address is the current endpoint, else the last read data
		logic cur_load_node; // cursor takes the current endpoint
		logic cur_load_data; // cursor follows the parent link just read
		logic root_take;     // cursor is the root: keep it
		logic comp_wr;       // point the cursor node at the root
		logic save_ra;       // keep the first root, move on to the second endpoint
		logic link;          // link the first root under the second
		logic load_out;      // fill the output register
	} ufef_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_mode;       // mode field of the offered transfer
		logic in_range;      // both offered endpoints lie below NODES
		logic is_root;       // read data equals the cursor
		logic next_is_root;  // read data equals the found root
		logic side;          // working on the second endpoint
		logic sweep_last;    // clearing pass writes its last entry
	} ufef_sts_t;

endpackage

/* src/ufef_dpath.sv */
// Datapath of the union-find edge filter: parent memory, walk cursor, counter, output register.
module ufef_dpath import ufef_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ufef_cmd_t         cmd,
	output ufef_sts_t         sts,
	input  logic              mode,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	input  logic [LEN_W-1:0]  edge_length,
	output logic              joined,
	output logic              new_road,
	output logic [NODE_W-1:0] edge_from,
	output logic [NODE_W-1:0] edge_to,
	output logic [CNT_W-1:0]  new_road_count
);

	logic [NODE_W-1:0] parent_mem [NODES];
	logic [NODE_W-1:0] rd_data_q;
	logic [NODE_W-1:0] rd_addr;
	logic              wr_en;
	logic [NODE_W-1:0] wr_addr;
	logic [NODE_W-1:0] wr_data;

	logic [NODE_W-1:0] a_q;
	logic [NODE_W-1:0] b_q;
	logic              len_nz_q;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] root_q;
	logic [NODE_W-1:0] ra_q;
	logic              side_q;
	logic [NODE_W-1:0] sweep_q;
	logic [CNT_W-1:0]  count_q;
	logic              joined_q;
	logic              new_road_q;

	logic              out_joined_q;
	logic              out_new_road_q;
	logic [NODE_W-1:0] out_from_q;
	logic [NODE_W-1:0] out_to_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [NODE_W-1:0] node_v;
	logic              roots_differ;
	logic              do_join;

	assign node_v       = side_q ? b_q : a_q;
	assign roots_differ = (ra_q != root_q);
	assign do_join      = cmd.link && roots_differ;

	assign rd_addr = cmd.rd_node ? node_v : rd_data_q;
	assign wr_en   = cmd.sweep_wr || cmd.comp_wr || do_join;

	always_comb begin
		if (cmd.sweep_wr) begin
			wr_addr = sweep_q;
			wr_data = sweep_q;
		end else if (cmd.comp_wr) begin
			wr_addr = cur_q;
			wr_data = root_q;
		end else begin
			wr_addr = ra_q;
			wr_data = root_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			parent_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= parent_mem[rd_addr];
	end

	assign sts.in_mode      = mode;
	assign sts.in_range     = ({1'b0, node_a} < (NODE_W+1)'(NODES)) &&
	                          ({1'b0, node_b} < (NODE_W+1)'(NODES));
	assign sts.is_root      = (rd_data_q == cur_q);
	assign sts.next_is_root = (rd_data_q == root_q);
	assign sts.side         = side_q;
	assign sts.sweep_last   = (sweep_q == NODE_LAST);

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q      <= node_a;
			b_q      <= node_b;
			len_nz_q <= (edge_length != '0);
		end
		if (cmd.cur_load_node) begin
			cur_q <= node_v;
		end else if (cmd.cur_load_data) begin
			cur_q <= rd_data_q;
		end
		if (cmd.root_take) begin
			root_q <= cur_q;
		end
		if (cmd.save_ra) begin
			ra_q <= root_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q     <= 1'b0;
			sweep_q    <= '0;
			count_q    <= '0;
			joined_q   <= 1'b0;
			new_road_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				side_q     <= 1'b0;
				joined_q   <= 1'b0;
				new_road_q <= 1'b0;
			end else begin
				if (cmd.save_ra) begin
					side_q <= 1'b1;
				end
				if (do_join) begin
					joined_q   <= 1'b1;
					new_road_q <= len_nz_q;
				end
			end
			// Wraps back to zero after the last entry, ready for the next pass.
			if (cmd.sweep_wr) begin
				sweep_q <= sweep_q + NODE_W'(1);
			end
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (do_join && len_nz_q && (count_q != CNT_MAX)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_joined_q   <= joined_q;
			out_new_road_q <= new_road_q;
			out_from_q     <= a_q;
			out_to_q       <= b_q;
			out_count_q    <= count_q;
		end
	end

	assign joined         = out_joined_q;
	assign new_road       = out_new_road_q;
	assign edge_from      = out_from_q;
	assign edge_to        = out_to_q;
	assign new_road_count = out_count_q;

endmodule

/* src/ufef_ctrl.sv */
// Controller of the union-find edge filter: sequences clearing, root walks, compression and link.
module ufef_ctrl import ufef_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ufef_sts_t sts,
	output ufef_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_SWEEP_RST,
		ST_SWEEP_CLR,
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_WALK,
		ST_COMP_START,
		ST_COMP_WALK,
		ST_LINK,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   take_in;

	assign out_free = !out_valid_q || !out_stall;
	assign take_in  = (state_q == ST_IDLE) && in_valid;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd               = '0;
		cmd.load_in       = take_in;
		cmd.clear_count   = take_in && !sts.in_mode;
		cmd.sweep_wr      = (state_q == ST_SWEEP_RST) || (state_q == ST_SWEEP_CLR);
		cmd.rd_node       = (state_q == ST_FIND_RD) || (state_q == ST_COMP_START);
		cmd.cur_load_node = cmd.rd_node;
		cmd.cur_load_data = ((state_q == ST_FIND_WALK) && !sts.is_root) ||
		                    ((state_q == ST_COMP_WALK) && !sts.next_is_root);
		cmd.root_take     = (state_q == ST_FIND_WALK) && sts.is_root;
		cmd.comp_wr       = (state_q == ST_COMP_WALK);
		cmd.save_ra       = (state_q == ST_COMP_WALK) && sts.next_is_root && !sts.side;
		cmd.link          = (state_q == ST_LINK);
		cmd.load_out      = (state_q == ST_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP_RST: begin
					if (sts.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP_CLR: begin
					if (sts.sweep_last) begin
						state_q <= ST_RESULT;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (!sts.in_mode) begin
							state_q <= ST_SWEEP_CLR;
						end else if (!sts.in_range) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_FIND_RD;
						end
					end
				end
				ST_FIND_RD: begin
					state_q <= ST_FIND_WALK;
				end
				ST_FIND_WALK: begin
					if (sts.is_root) begin
						state_q <= ST_COMP_START;
					end
				end
				ST_COMP_START: begin
					state_q <= ST_COMP_WALK;
				end
				ST_COMP_WALK: begin
					if (sts.next_is_root) begin
						state_q <= sts.side ? ST_LINK : ST_FIND_RD;
					end
				end
				ST_LINK: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/union_find_edge_filter.sv */
// Top level of the union-find edge filter: disjoint-set core of a minimum spanning tree builder.
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, mode, node_a, node_b,         | into block
//          | edge_length                                       |
//  out     | out_valid, out_stall, joined, new_road,           | out of block
//          | edge_from, edge_to, new_road_count                |
//
// An edge walks from its first endpoint to the root, one parent link read per cycle, then
// walks that path again and points each node on it at the root; the same follows for the
// second endpoint, and then the first root is linked under the second. The parent memory
// has one read port and one write port. A clear item writes every one of the 1024 parent
// entries back to itself, one parent entry written per cycle; after reset the same
// clearing pass runs while in_stall stays high.
// in_stall is low only in the idle state; an unclaimed result sits in the output register
// and the next item is still taken, finishing only once that register frees up.
module union_find_edge_filter import ufef_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	input  logic [LEN_W-1:0]  edge_length,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              joined,
	output logic              new_road,
	output logic [NODE_W-1:0] edge_from,
	output logic [NODE_W-1:0] edge_to,
	output logic [CNT_W-1:0]  new_road_count
);

`include "union_find_edge_filter_assert.svh"

	ufef_cmd_t cmd;
	ufef_sts_t sts;

	// Sequence the work: clearing pass, root walk and compression per endpoint, then link.
	ufef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the parent links, the walk cursor, the running count and the result register.
	ufef_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.node_a         (node_a),
		.node_b         (node_b),
		.edge_length    (edge_length),
		.joined         (joined),
		.new_road       (new_road),
		.edge_from      (edge_from),
		.edge_to        (edge_to),
		.new_road_count (new_road_count)
	);

	// A new road is always a joining edge.
	`UFEF_ASSERT_NOW(a_new_road_joined, out_valid && new_road, joined, "new road without join")
	// An edge from a node to itself never merges two sets.
	`UFEF_ASSERT_NOW(a_self_loop, out_valid && (edge_from == edge_to), !joined, "self loop joined")
	// A clear transfer starts the clearing pass, so the input side stalls right after.
	`UFEF_ASSERT_NEXT(a_clear_stalls, in_valid && !in_stall && !mode, in_stall, "clear not stalled")

endmodule

/* verif/testbench.sv */
// Self-checking testbench of the union-find edge filter: predicted forest, directed and random edges, stalls.
`timescale 1ns / 1ps

module testbench;
	import ufef_pkg::*;

	// Mode field codes of an input transfer.
	localparam logic MODE_CLEAR = 1'b0;
	localparam logic MODE_EDGE  = 1'b1;

	localparam int HOLD_CYCLES   = 400;     // long receiver hold-off to back up the block
	localparam int SETTLE_CYCLES = 1100;    // covers a full clearing pass
	localparam int PHASE_LEN     = 150;     // random transfers per idling phase

	// One expected result transfer.
	typedef struct {
		logic              joined;
		logic              new_road;
		logic [NODE_W-1:0] edge_from;
		logic [NODE_W-1:0] edge_to;
		logic [CNT_W-1:0]  new_road_count;
	} road_result_t;

	// Keeps its own copy of the parent links and the road count, and the queue of
	// results still owed by the block.
	class forest_predictor;
		logic [NODE_W-1:0] parent [NODES];
		logic [CNT_W-1:0]  road_total;
		road_result_t      owed_results [$];
		int                errors;

		function new();
			errors = 0;
			clear_forest();
		endfunction

		function void clear_forest();
			foreach (parent[i])
				parent[i] = NODE_W'(i);
			road_total = '0;
		endfunction

		// Walk to the root, then point every node on the path straight at it.
		function logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] v);
			logic [NODE_W-1:0] root;
			logic [NODE_W-1:0] cur;
			logic [NODE_W-1:0] nxt;
			root = v;
			while (parent[root] != root)
				root = parent[root];
			cur = v;
			while (cur != root) begin
				nxt = parent[cur];
				parent[cur] = root;
				cur = nxt;
			end
			return root;
		endfunction

		// Apply one accepted input transfer and queue the result it must cause.
		function void note_transfer(logic m, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
				logic [LEN_W-1:0] len);
			road_result_t      res;
			logic [NODE_W-1:0] ra;
			logic [NODE_W-1:0] rb;
			res.joined   = 1'b0;
			res.new_road = 1'b0;
			if (m == MODE_CLEAR) begin
				clear_forest();
			end else if (int'(a) < NODES && int'(b) < NODES) begin
				ra = root_of(a);
				rb = root_of(b);
				if (ra != rb) begin
					parent[ra] = rb;
					res.joined = 1'b1;
					if (len != '0) begin
						res.new_road = 1'b1;
						if (road_total != CNT_MAX)
							road_total = road_total + 1'b1;
					end
				end
			end
			res.edge_from      = a;
			res.edge_to        = b;
			res.new_road_count = road_total;
			owed_results.insert(owed_results.size(), res);
		endfunction

		// Compare one result transfer against the oldest owed result.
		function void check_result(logic j, logic nr, logic [NODE_W-1:0] ef,
				logic [NODE_W-1:0] et, logic [CNT_W-1:0] cnt);
			road_result_t exp_res;
			if (owed_results.size() == 0) begin
				$error("result transfer with no result owed");
				errors++;
				return;
			end
			exp_res = owed_results.pop_front();
			if (j !== exp_res.joined) begin
				$error("joined: expected %0d, got %0d", exp_res.joined, j);
				errors++;
			end
			if (nr !== exp_res.new_road) begin
				$error("new_road: expected %0d, got %0d", exp_res.new_road, nr);
				errors++;
			end
			if (ef !== exp_res.edge_from) begin
				$error("edge_from: expected %0d, got %0d", exp_res.edge_from, ef);
				errors++;
			end
			if (et !== exp_res.edge_to) begin
				$error("edge_to: expected %0d, got %0d", exp_res.edge_to, et);
				errors++;
			end
			if (cnt !== exp_res.new_road_count) begin
				$error("new_road_count: expected %0d, got %0d", exp_res.new_road_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              mode        = MODE_EDGE;
	logic [NODE_W-1:0] node_a      = '0;
	logic [NODE_W-1:0] node_b      = '0;
	logic [LEN_W-1:0]  edge_length = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              joined;
	logic              new_road;
	logic [NODE_W-1:0] edge_from;
	logic [NODE_W-1:0] edge_to;
	logic [CNT_W-1:0]  new_road_count;

	// Idling knobs, in percent per cycle.
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	// Hold-off request: the sender toggles it, the receiver counts the stretch itself.
	logic hold_kick = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	forest_predictor forest = new();

	logic [NODE_W-1:0] perm [NODES];
	int                random_count;

	union_find_edge_filter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.node_a         (node_a),
		.node_b         (node_b),
		.edge_length    (edge_length),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.joined         (joined),
		.new_road       (new_road),
		.edge_from      (edge_from),
		.edge_to        (edge_to),
		.new_road_count (new_road_count)
	);

	always #1 clk = ~clk;

	// Receiver: check each result transfer, then pick the stall for the next cycle.
	// A requested hold-off overrides the random stall until it runs out.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			forest.check_result(joined, new_road, edge_from, edge_to, new_road_count);
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Offer one item at the current edge and hold it until the transfer; then
	// either keep valid high for the next item or drop it for a random gap.
	task automatic send_item(input logic m, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b, input logic [LEN_W-1:0] len);
		mode        <= m;
		node_a      <= a;
		node_b      <= b;
		edge_length <= len;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		forest.note_transfer(m, a, b, len);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	// Pause the sender until every owed result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (forest.owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Rotate through the idling phases as random transfers go by.
	task automatic set_phase(input int n);
		case ((n / PHASE_LEN) % 4)
			0: begin
				tx_idle_pct  <= 0;
				rx_stall_pct <= 0;
			end
			1: begin
				tx_idle_pct  <= 63;
				rx_stall_pct <= 0;
			end
			2: begin
				tx_idle_pct  <= 0;
				rx_stall_pct <= 63;
			end
			default: begin
				tx_idle_pct  <= 22;
				rx_stall_pct <= 22;
			end
		endcase
	endtask

	function automatic logic [LEN_W-1:0] nonzero_len();
		logic [LEN_W-1:0] len;
		if ($urandom_range(3) == 0)
			return '1;
		do
			len = $urandom;
		while (len == '0);
		return len;
	endfunction

	function automatic logic [LEN_W-1:0] any_len();
		if ($urandom_range(2) == 0)
			return '0;
		return nonzero_len();
	endfunction

	// Shuffle the node order used to grow one tree over every node.
	function automatic void shuffle_nodes();
		int               j;
		logic [NODE_W-1:0] t;
		foreach (perm[i])
			perm[i] = NODE_W'(i);
		for (int i = NODES - 1; i > 0; i--) begin
			j       = $urandom_range(i);
			t       = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
	endfunction

	initial begin
		int                k;
		int                j;
		logic [NODE_W-1:0] base;

		// Hold reset, then wait out the clearing pass via in_stall.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, same node, same set, zero length, deep chain, clears.
		send_item(MODE_EDGE, 10'd0, 10'd1023, 32'hFFFF_FFFF);
		send_item(MODE_EDGE, 10'd1023, 10'd0, 32'd0);
		send_item(MODE_EDGE, 10'd5, 10'd5, 32'd1);
		send_item(MODE_EDGE, 10'd2, 10'd3, 32'd0);
		send_item(MODE_EDGE, 10'd10, 10'd11, 32'd1);
		send_item(MODE_EDGE, 10'd11, 10'd12, 32'd1);
		send_item(MODE_EDGE, 10'd12, 10'd13, 32'd1);
		send_item(MODE_EDGE, 10'd13, 10'd14, 32'd1);
		send_item(MODE_EDGE, 10'd14, 10'd15, 32'd1);
		send_item(MODE_EDGE, 10'd10, 10'd20, 32'd7);
		send_item(MODE_EDGE, 10'd10, 10'd15, 32'h8000_0000);
		send_item(MODE_EDGE, 10'd20, 10'd2, 32'h7FFF_FFFF);
		send_item(MODE_CLEAR, 10'd1023, 10'h2AA, 32'hFFFF_FFFF);
		send_item(MODE_EDGE, 10'd0, 10'd1023, 32'd1);
		send_item(MODE_EDGE, 10'h155, 10'h2AA, 32'h8000_0000);
		send_item(MODE_EDGE, 10'h2AA, 10'd0, 32'd0);
		send_item(MODE_CLEAR, 10'd0, 10'd0, 32'd0);

		// Random: grow one tree over all nodes so the count reaches its top,
		// mixed with same-set searches and stray joins.
		shuffle_nodes();
		random_count = 0;
		send_item(MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom);
		k = 1;
		while (k < NODES) begin
			set_phase(random_count);
			if (random_count == 100)
				hold_kick <= ~hold_kick;
			if (random_count == 500)
				wait_drained();
			if ($urandom_range(9) != 0) begin
				j = $urandom_range(k - 1);
				if ($urandom_range(1) == 0)
					send_item(MODE_EDGE, perm[k], perm[j], nonzero_len());
				else
					send_item(MODE_EDGE, perm[j], perm[k], nonzero_len());
				k++;
			end else if ($urandom_range(1) == 0) begin
				send_item(MODE_EDGE, perm[$urandom_range(k - 1)], perm[$urandom_range(k - 1)],
					any_len());
			end else begin
				send_item(MODE_EDGE, NODE_W'($urandom), NODE_W'($urandom), nonzero_len());
			end
			random_count++;
		end

		// Random: small windows of nodes between clears, so sets merge and split often.
		base = '0;
		for (int t = 0; t < 220; t++) begin
			set_phase(random_count);
			if (t % 40 == 0) begin
				base = NODE_W'($urandom_range(NODES - 16));
				send_item(MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom);
			end else if ($urandom_range(9) == 0) begin
				send_item(MODE_EDGE, NODE_W'($urandom), NODE_W'($urandom), any_len());
			end else begin
				send_item(MODE_EDGE, base + NODE_W'($urandom_range(15)),
					base + NODE_W'($urandom_range(15)), any_len());
			end
			random_count++;
		end

		// Drain, then give the block time to show any stray result.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (forest.errors == 0 && forest.owed_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: end a hung run.
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* union_find_edge_filter.f */
+incdir+src
src/ufef_pkg.sv
src/ufef_dpath.sv
src/ufef_ctrl.sv
src/union_find_edge_filter.sv
verif/testbench.sv
